// ===== hw/rtl/rcu_pkg.sv =====
// Shared constants, types and helpers for the radix converter.
package rcu_pkg;

	localparam int MAX_DIGITS_DEF = 32;
	localparam int VALUE_BITS_DEF = 31;

	localparam int BASE_W   = 5;
	localparam int DIGIT_W  = 4;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [BASE_W-1:0] SRC_BASE_RST = BASE_W'(10);
	localparam logic [BASE_W-1:0] TGT_BASE_RST = BASE_W'(2);
	localparam logic [BASE_W-1:0] DEC_BASE     = BASE_W'(10);
	localparam logic [BASE_W-1:0] MIN_BASE     = BASE_W'(2);
	localparam logic [BASE_W-1:0] HEX_BASE     = BASE_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = CFG_IDX_W'(1);

	localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_BAD_BASE  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = STATUS_W'(2);

	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} rcu_div_rsp_t;

	function automatic logic base_ok(input logic [BASE_W-1:0] sb, input logic [BASE_W-1:0] tb);
		logic s_ok;
		logic t_ok;
		s_ok = (sb >= MIN_BASE) && (sb <= DEC_BASE);
		t_ok = ((tb >= MIN_BASE) && (tb <= DEC_BASE)) || (tb == HEX_BASE);
		return s_ok && t_ok;
	endfunction

endpackage

// ===== hw/rtl/radix_converter_unit.sv =====
// Radix converter: source-base digits written in decimal, out as target-base digits.
// Each decimal input digit and each output digit costs one division in the shared
// divider; the output digits are then loaded, one per beat, while the output is free.
// One item at a time; the next item is taken once the last beat is loaded and the
// output register is free. Reset: source base 10, target base 2, idle; digit buffer is not cleared.
module radix_converter_unit #(
	parameter int MAX_DIGITS = rcu_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_BITS = rcu_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [VALUE_BITS-1:0]         value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [rcu_pkg::DIGIT_W-1:0]   digit,
	output logic [rcu_pkg::STATUS_W-1:0]  status,
	output logic                          last_digit,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcu_pkg::BASE_W-1:0]    cfg_data
);
	import rcu_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DDIV,
		S_TDIV,
		S_EMIT,
		S_ERR
	} state_t;

	state_t               state_q;
	logic [BASE_W-1:0]    src_base_q;
	logic [BASE_W-1:0]    tgt_base_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] place_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     rd_q;
	logic [STATUS_W-1:0]  err_q;
	logic                 div_start_q;
	logic [VALUE_BITS-1:0] div_num_q;
	logic [BASE_W-1:0]    div_den_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 last_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic [DIGIT_W-1:0]   buf_mem [MAX_DIGITS];

	logic [VALUE_BITS-1:0] quotient;
	rcu_div_rsp_t          div_rsp;

	logic                  item_take;
	logic                  out_free;
	logic                  buf_we;
	logic                  emit_load;
	logic [VALUE_BITS-1:0] acc_sum;
	logic [VALUE_BITS-1:0] place_next;

	rcu_div #(
		.W(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (div_den_q),
		.quotient (quotient),
		.rsp      (div_rsp)
	);

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = (state_q != S_IDLE) || !out_free;
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign acc_sum    = acc_q + VALUE_BITS'(VALUE_BITS'(div_rsp.rem) * place_q);
	assign place_next = VALUE_BITS'(place_q * VALUE_BITS'(src_base_q));

	assign buf_we    = (state_q == S_TDIV) && div_rsp.done;
	assign emit_load = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= SRC_BASE_RST;
			tgt_base_q <= TGT_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SOURCE_BASE) begin
				src_base_q <= cfg_data;
			end else if (cfg_index == CFG_TARGET_BASE) begin
				tgt_base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_take) begin
						acc_q   <= '0;
						place_q <= VALUE_BITS'(1);
						cnt_q   <= '0;
						if (!base_ok(src_base_q, tgt_base_q)) begin
							err_q   <= ST_BAD_BASE;
							state_q <= S_ERR;
						end else if (value == '0) begin
							div_num_q   <= '0;
							div_den_q   <= tgt_base_q;
							div_start_q <= 1'b1;
							state_q     <= S_TDIV;
						end else begin
							div_num_q   <= value;
							div_den_q   <= DEC_BASE;
							div_start_q <= 1'b1;
							state_q     <= S_DDIV;
						end
					end
				end
				S_DDIV: begin
					if (div_rsp.done) begin
						if (BASE_W'(div_rsp.rem) >= src_base_q) begin
							err_q   <= ST_BAD_DIGIT;
							acc_q   <= '0;
							state_q <= S_ERR;
						end else begin
							acc_q       <= acc_sum;
							place_q     <= place_next;
							div_start_q <= 1'b1;
							if (quotient == '0) begin
								div_num_q <= acc_sum;
								div_den_q <= tgt_base_q;
								state_q   <= S_TDIV;
							end else begin
								div_num_q <= quotient;
								div_den_q <= DEC_BASE;
							end
						end
					end
				end
				S_TDIV: begin
					if (div_rsp.done) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (quotient == '0 || cnt_q == CNT_W'(MAX_DIGITS - 1)) begin
							rd_q    <= cnt_q[IDX_W-1:0];
							state_q <= S_EMIT;
						end else begin
							div_num_q   <= quotient;
							div_start_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						last_q      <= (rd_q == '0);
						if (rd_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_q <= rd_q - IDX_W'(1);
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= err_q;
						last_q      <= 1'b1;
						acc_q       <= '0;
						cnt_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digit buffer and the output digit register
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[cnt_q[IDX_W-1:0]] <= div_rsp.rem;
		end
		if (emit_load) begin
			digit_q <= buf_mem[rd_q];
		end else if (state_q == S_ERR && out_free) begin
			digit_q <= '0;
		end
	end

	assign result_valid = out_valid_q;
	assign digit        = digit_q;
	assign status       = status_q;
	assign last_digit   = last_q;

endmodule

// ===== hw/rtl/rcu_div.sv =====
// Bit-serial restoring divider by a small base, one quotient bit per cycle.
module rcu_div #(
	parameter int W = rcu_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [W-1:0]               dividend,
	input  logic [rcu_pkg::BASE_W-1:0] divisor,
	output logic [W-1:0]               quotient,
	output rcu_pkg::rcu_div_rsp_t      rsp
);
	import rcu_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [W-1:0]       quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [BASE_W-1:0]  den_q;

	logic [BASE_W-1:0]  partial;
	logic               ge;
	logic [BASE_W-1:0]  diff;

	assign partial = {rem_q, quo_q[W-1]};
	assign ge      = (partial >= den_q);
	assign diff    = partial - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
